### design/dkit_pkg.sv
// Shared constants and types for the distinct key id table.
package dkit_pkg;

  localparam int KEY_W   = 64;
  localparam int COUNT_W = 16;
  localparam int ID_W    = 4;
  localparam int USED_W  = 5;

  typedef logic [1:0] status_t;

  localparam status_t ST_ADDED     = 2'd0;
  localparam status_t ST_MATCHED   = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_FULL      = 2'd3;

  localparam logic CMD_REGISTER = 1'b0;
  localparam logic CMD_LOOKUP   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_MISS = 3'b100
  } state_t;

endpackage

### design/dkit_store.sv
// Key and count memories: one read port and one write port each, registered read data.
module dkit_store #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic                         clk,
  input  logic [IDX_W-1:0]             rd_addr,
  output logic [dkit_pkg::KEY_W-1:0]   rd_key,
  output logic [dkit_pkg::COUNT_W-1:0] rd_cnt,
  input  logic                         key_we,
  input  logic                         cnt_we,
  input  logic [IDX_W-1:0]             wr_addr,
  input  logic [dkit_pkg::KEY_W-1:0]   wr_key,
  input  logic [dkit_pkg::COUNT_W-1:0] wr_cnt
);
  import dkit_pkg::*;

  logic [KEY_W-1:0]   key_mem [DEPTH];
  logic [COUNT_W-1:0] cnt_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    rd_key <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[wr_addr] <= wr_cnt;
    end
    rd_cnt <= cnt_mem[rd_addr];
  end

endmodule

### design/distinct_key_id_table.sv
// Distinct key id table: top level with search sequencer and result register.
// Sequence: a taken transaction compares the used entries in order from entry 0 and strobes
//   done on a match; a miss strobes done after the last used entry, or via S_MISS if empty.
// Flow: one transaction at a time; the scan reads one entry per cycle from the key memory
//   port. start may be taken while done is high.
// Reset: entry count and control cleared; memories are not cleared (never read before written).
module distinct_key_id_table #(
  parameter int              MAX_ENTRIES = 16,
  parameter longint unsigned MAX_MEMBERS = 65535
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         cmd,
  input  logic [dkit_pkg::KEY_W-1:0]   key_hash,
  output logic                         done,
  output dkit_pkg::status_t            status,
  output logic [dkit_pkg::ID_W-1:0]    entry_id,
  output logic [dkit_pkg::COUNT_W-1:0] member_count,
  output logic [dkit_pkg::USED_W-1:0]  entries_used
);
  import dkit_pkg::*;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  // saturation point of a member count: the smaller of MAX_MEMBERS and the field maximum
  localparam logic [COUNT_W-1:0] CountCap =
    (MAX_MEMBERS > longint'({COUNT_W{1'b1}})) ? {COUNT_W{1'b1}} : COUNT_W'(MAX_MEMBERS);
  localparam logic [CNT_W-1:0] UsedFull = CNT_W'(MAX_ENTRIES);

  // control state
  state_t           state, state_next;
  logic [IDX_W-1:0] scan_idx, scan_next;   // entry whose data sits on the read port
  logic [CNT_W-1:0] used, used_next;       // entries in use

  // transaction held during the scan
  logic             cmd_q;
  logic [KEY_W-1:0] key_q;

  // memory port signals
  logic [IDX_W-1:0]   rd_addr;
  logic [KEY_W-1:0]   rd_key;
  logic [COUNT_W-1:0] rd_cnt;
  logic               key_we, cnt_we;
  logic [IDX_W-1:0]   wr_addr;
  logic [COUNT_W-1:0] wr_cnt;

  // result to be registered
  logic               res_fire;
  status_t            res_status;
  logic [IDX_W-1:0]   res_id;
  logic [COUNT_W-1:0] res_cnt;

  logic               hit, last, miss_now;
  logic [COUNT_W-1:0] inc_cnt;

  dkit_store #(
    .DEPTH (MAX_ENTRIES),
    .IDX_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_key  (rd_key),
    .rd_cnt  (rd_cnt),
    .key_we  (key_we),
    .cnt_we  (cnt_we),
    .wr_addr (wr_addr),
    .wr_key  (key_q),
    .wr_cnt  (wr_cnt)
  );

  assign busy = (state != S_IDLE);

  assign hit     = (rd_key == key_q);
  assign last    = (CNT_W'(scan_idx) == (used - CNT_W'(1)));
  assign inc_cnt = (rd_cnt < CountCap) ? (rd_cnt + COUNT_W'(1)) : rd_cnt;
  // miss: empty table, or the last used entry compared without a hit
  assign miss_now = (state == S_MISS) || ((state == S_SCAN) && !hit && last);

  always_comb begin
    state_next = state;
    scan_next  = scan_idx;
    used_next  = used;
    rd_addr    = '0;
    key_we     = 1'b0;
    cnt_we     = 1'b0;
    wr_addr    = scan_idx;
    wr_cnt     = inc_cnt;
    res_fire   = 1'b0;
    res_status = ST_NOT_FOUND;
    res_id     = '0;
    res_cnt    = '0;

    unique case (state)
      S_IDLE: begin
        // entry 0 is read while the transaction is taken
        if (start) begin
          scan_next  = '0;
          state_next = (used == '0) ? S_MISS : S_SCAN;
        end
      end
      S_SCAN: begin
        // prefetch the next entry; hold the address on the last one to stay in range
        rd_addr = last ? scan_idx : (scan_idx + IDX_W'(1));
        if (hit) begin
          res_fire   = 1'b1;
          res_status = ST_MATCHED;
          res_id     = scan_idx;
          state_next = S_IDLE;
          if (cmd_q == CMD_REGISTER) begin
            cnt_we  = 1'b1;
            res_cnt = inc_cnt;
          end else begin
            res_cnt = rd_cnt;
          end
        end else if (!last) begin
          scan_next = scan_idx + IDX_W'(1);
        end
      end
      S_MISS: begin
        // empty table; handled by the miss path below
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (miss_now) begin
      res_fire   = 1'b1;
      state_next = S_IDLE;
      if (cmd_q == CMD_LOOKUP) begin
        res_status = ST_NOT_FOUND;
      end else if (used == UsedFull) begin
        res_status = ST_FULL;
      end else begin
        // append at the next free slot with a count of one
        res_status = ST_ADDED;
        res_id     = used[IDX_W-1:0];
        res_cnt    = COUNT_W'(1);
        key_we     = 1'b1;
        cnt_we     = 1'b1;
        wr_addr    = used[IDX_W-1:0];
        wr_cnt     = COUNT_W'(1);
        used_next  = used + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      used  <= used_next;
      done  <= res_fire;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    scan_idx <= scan_next;
    if (start && !busy) begin
      cmd_q <= cmd;
      key_q <= key_hash;
    end
    if (res_fire) begin
      status       <= res_status;
      entry_id     <= ID_W'(res_id);
      member_count <= res_cnt;
      entries_used <= USED_W'(used_next);
    end
  end

endmodule

### verif/dkit_checker.sv
// Checker for the distinct key id table: predicts each transaction and compares results.
module dkit_checker #(
  parameter int              MAX_ENTRIES = 16,
  parameter longint unsigned MAX_MEMBERS = 65535
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  logic                         cmd,
  input  logic [dkit_pkg::KEY_W-1:0]   key_hash,
  input  logic                         done,
  input  dkit_pkg::status_t            status,
  input  logic [dkit_pkg::ID_W-1:0]    entry_id,
  input  logic [dkit_pkg::COUNT_W-1:0] member_count,
  input  logic [dkit_pkg::USED_W-1:0]  entries_used,
  output int                           fail_count,
  output int                           pending
);
  import dkit_pkg::*;

  typedef struct packed {
    status_t             status;
    logic [ID_W-1:0]     id;
    logic [COUNT_W-1:0]  count;
    logic [USED_W-1:0]   used;
  } outcome_t;

  // hardware count field caps at 16 bits
  localparam longint unsigned COUNT_CAP = (MAX_MEMBERS > 65535) ? 65535 : MAX_MEMBERS;

  outcome_t           expected_outcomes[$];
  logic [KEY_W-1:0]   held_keys[MAX_ENTRIES];
  logic [COUNT_W-1:0] held_counts[MAX_ENTRIES];
  int unsigned        keys_held;

  // run statistics, read by the top for its summary
  int unsigned status_seen[4];
  int unsigned saturated_hits;
  int unsigned register_txns;
  int unsigned lookup_txns;

  // Search in insertion order; register counts a hit or appends (full when no room), lookup only reports.
  function automatic outcome_t tally_key(input logic is_lookup, input logic [KEY_W-1:0] key);
    outcome_t o;
    int       hit;
    hit = -1;
    for (int i = 0; i < keys_held; i++)
      if (hit < 0 && held_keys[i] == key) hit = i;
    o = '0;
    if (hit >= 0) begin
      if (!is_lookup) begin
        if (held_counts[hit] < COUNT_CAP) held_counts[hit] = held_counts[hit] + 1'b1;
        else saturated_hits++;
      end
      o.status = ST_MATCHED;
      o.id     = hit[ID_W-1:0];
      o.count  = held_counts[hit];
    end else if (is_lookup) begin
      o.status = ST_NOT_FOUND;
    end else if (keys_held >= MAX_ENTRIES) begin
      o.status = ST_FULL;
    end else begin
      held_keys[keys_held]   = key;
      held_counts[keys_held] = COUNT_W'(1);
      o.status = ST_ADDED;
      o.id     = keys_held[ID_W-1:0];
      o.count  = COUNT_W'(1);
      keys_held++;
    end
    o.used = keys_held[USED_W-1:0];
    status_seen[o.status]++;
    return o;
  endfunction

  function automatic void check_field(input string field, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", field, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    outcome_t want;
    if (!rst) begin
      if (done) begin
        if (expected_outcomes.size() == 0) begin
          $error("result strobed with no transaction outstanding");
          fail_count++;
        end else begin
          want = expected_outcomes.pop_front();
          check_field("status", 64'(want.status), 64'(status));
          check_field("entry_id", 64'(want.id), 64'(entry_id));
          check_field("member_count", 64'(want.count), 64'(member_count));
          check_field("entries_used", 64'(want.used), 64'(entries_used));
        end
      end
      if (start && !busy) begin
        if (cmd == CMD_LOOKUP) lookup_txns++;
        else register_txns++;
        expected_outcomes.push_back(tally_key(cmd == CMD_LOOKUP, key_hash));
      end
    end
    pending = expected_outcomes.size();
  end

endmodule

### verif/distinct_key_id_table_test.sv
// Testbench top for the distinct key id table: stimulus, pacing and verdict.
module distinct_key_id_table_test;
  import dkit_pkg::*;

  localparam int              MAX_ENTRIES = 16;
  localparam longint unsigned MAX_MEMBERS = 65535;
  localparam int              RANDOM_TXNS = 1800;
  // repeats of one key to run its count up on entry 0
  localparam int              SATURATE_TXNS = 40;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic                cmd;
  logic [KEY_W-1:0]    key_hash;
  logic                done;
  status_t             status;
  logic [ID_W-1:0]     entry_id;
  logic [COUNT_W-1:0]  member_count;
  logic [USED_W-1:0]   entries_used;
  int                  fail_count;
  int                  pending;

  distinct_key_id_table #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_MEMBERS (MAX_MEMBERS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .key_hash     (key_hash),
    .done         (done),
    .status       (status),
    .entry_id     (entry_id),
    .member_count (member_count),
    .entries_used (entries_used)
  );

  // The checker sits beside the block on the same wires: it predicts every
  // accepted transaction and compares each strobed result in order.
  dkit_checker #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_MEMBERS (MAX_MEMBERS)
  ) scoreboard (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .key_hash     (key_hash),
    .done         (done),
    .status       (status),
    .entry_id     (entry_id),
    .member_count (member_count),
    .entries_used (entries_used),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // 12-unit clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Watchdog. Worst case is roughly 1.9k transactions, each a full scan plus the longest
  // pacing gap, about 0.9M units; allow a wide margin.
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  // keys sent with a register command, reused to hit existing entries
  logic [KEY_W-1:0] registered_keys[$];
  int               burst_left;

  // Present one transaction at the current falling edge and hold it until the
  // block takes it (start high, busy low at a rising edge). Returns on the
  // falling edge after acceptance, so a following transaction can keep start
  // high without a low pulse.
  task automatic send_txn(input logic op, input logic [KEY_W-1:0] key);
    start    <= 1'b1;
    cmd      <= op;
    key_hash <= key;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Sender pacing: bursts of back-to-back transactions, then a random gap.
  // Gaps of random length land anywhere within a scan of the table.
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 7);
      gap = $urandom_range(1, 20);
      start    <= 1'b0;
      // junk on the data pins while idle; must be ignored
      cmd      <= 1'($urandom_range(0, 1));
      key_hash <= {$urandom, $urandom};
      repeat (gap) @(negedge clk);
    end
  endtask

  // Hold off until every outstanding transaction has produced its result.
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  initial begin : stimulus
    logic [KEY_W-1:0] key;
    logic             op;
    int               pick;
    rst        = 1'b1;
    start      = 1'b0;
    cmd        = CMD_REGISTER;
    key_hash   = '0;
    burst_left = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: miss on the empty table, extreme keys, first match,
    // lookup hit and miss, and near neighbors of stored keys.
    send_txn(CMD_LOOKUP,   '0);
    send_txn(CMD_REGISTER, '0);
    send_txn(CMD_REGISTER, '1);
    send_txn(CMD_LOOKUP,   '1);
    send_txn(CMD_REGISTER, '0);
    send_txn(CMD_LOOKUP,   64'h8000_0000_0000_0000);
    send_txn(CMD_REGISTER, 64'h0000_0000_0000_0001);
    send_txn(CMD_REGISTER, 64'h7FFF_FFFF_FFFF_FFFF);
    send_txn(CMD_LOOKUP,   64'h0000_0000_0000_0001);
    drain();
    registered_keys = '{64'h0, '1, 64'h1, 64'h7FFF_FFFF_FFFF_FFFF};

    // Back-to-back registration of the same key: its count on entry 0 climbs
    // every transaction, then a lookup reads it back.
    for (int n = 0; n < SATURATE_TXNS; n++)
      send_txn(CMD_REGISTER, '0);
    send_txn(CMD_LOOKUP, '0);
    drain();

    // Random phase. The table fills early in this phase, after which new keys
    // report full; most traffic reuses known keys so matches cover every entry.
    for (int n = 0; n < RANDOM_TXNS; n++) begin
      pick = $urandom_range(0, 99);
      op   = ($urandom_range(0, 9) < 3) ? CMD_LOOKUP : CMD_REGISTER;
      if (pick < 60)
        key = registered_keys[$urandom_range(0, registered_keys.size() - 1)];
      else if (pick < 75)   // one bit away from a known key
        key = registered_keys[$urandom_range(0, registered_keys.size() - 1)]
              ^ (64'd1 << $urandom_range(0, KEY_W - 1));
      else
        key = {$urandom, $urandom};
      if (op == CMD_REGISTER) registered_keys.push_back(key);
      send_txn(op, key);
      // one full stop in the middle: let the block go completely quiet
      if (n == RANDOM_TXNS / 2) drain();
      else pace();
    end

    drain();
    // wait out a full scan of the table; any stray strobe shows up by then
    repeat (MAX_ENTRIES + 4) @(posedge clk);

    $display("Covered %0d register and %0d lookup transactions; table held %0d keys at the end.",
             scoreboard.register_txns, scoreboard.lookup_txns, scoreboard.keys_held);
    $display("Outcomes: %0d added, %0d matched, %0d not found, %0d full; %0d counts held at ceiling.",
             scoreboard.status_seen[ST_ADDED], scoreboard.status_seen[ST_MATCHED],
             scoreboard.status_seen[ST_NOT_FOUND], scoreboard.status_seen[ST_FULL],
             scoreboard.saturated_hits);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
